FILE: hw/rtl/lotl_pkg.sv
// ----------------------------------------------------------------------------
// LED on-time limiter package
// Shared widths, constants, status codes and types of the LED on-time limiter.
// ----------------------------------------------------------------------------
package lotl_pkg;

  // Field widths.
  localparam int unsigned BrightWidth = 8;
  localparam int unsigned OnTimeWidth = 20;
  localparam int unsigned LevelWidth  = 16;
  localparam int unsigned StatusWidth = 3;

  // Width of the stored countdown; on-times beyond it saturate.
  localparam int unsigned TimeWidth = 20;

  // Brightness times full scale, and its scaling by 1/100 as a reciprocal.
  localparam int unsigned ProdWidth  = BrightWidth + LevelWidth;
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipWidth = 2 * ProdWidth;
  localparam logic [ProdWidth-1:0] RecipMul = ProdWidth'(10737419);

  // Full scale after reset.
  localparam logic [LevelWidth-1:0] FullScaleReset = LevelWidth'(499);

  // Allowed on-time as a piecewise linear function of brightness.
  localparam int unsigned LimitWidth = 18;
  localparam logic [LimitWidth-1:0] AllowFull      = LimitWidth'(500);
  localparam logic [LimitWidth-1:0] AllowHighBase  = LimitWidth'(1500);
  localparam logic [LimitWidth-1:0] AllowHighSlope = LimitWidth'(10);
  localparam logic [LimitWidth-1:0] AllowMidBase   = LimitWidth'(148500);
  localparam logic [LimitWidth-1:0] AllowMidSlope  = LimitWidth'(2950);
  localparam logic [BrightWidth-1:0] BrightFull = BrightWidth'(100);
  localparam logic [BrightWidth-1:0] BrightHigh = BrightWidth'(50);
  localparam logic [BrightWidth-1:0] BrightMid  = BrightWidth'(30);

  // Input item kinds.
  localparam logic CmdBright = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    StApplied = 3'd0,
    StRefused = 3'd1,
    StRange   = 3'd2,
    StIdle    = 3'd3,
    StExpired = 3'd4
  } status_e;

  // Outcome of the on-time check of a brightness command.
  typedef struct packed {
    logic refuse;
    logic in_range;
  } check_t;

endpackage

FILE: hw/rtl/lotl_limit.sv
// ----------------------------------------------------------------------------
// LED on-time limiter: on-time check
// Computes the allowed on-time for a brightness and decides whether an
// unforced command is refused and whether its brightness is in range.
// ----------------------------------------------------------------------------
module lotl_limit (
  input  logic [lotl_pkg::BrightWidth-1:0] brightness_i,
  input  logic [lotl_pkg::OnTimeWidth-1:0] on_time_ms_i,
  input  logic                             force_req_i,
  output lotl_pkg::check_t                 check_o
);

  logic [lotl_pkg::LimitWidth-1:0] limit;
  logic [lotl_pkg::LimitWidth-1:0] bright_ext;
  logic                            has_limit;

  assign bright_ext = lotl_pkg::LimitWidth'(brightness_i);

  // Allowed time per brightness band; no limit at the low end.
  always_comb begin
    if (brightness_i >= lotl_pkg::BrightFull) begin
      limit = lotl_pkg::AllowFull;
    end else if (brightness_i > lotl_pkg::BrightHigh) begin
      limit = lotl_pkg::AllowHighBase - (bright_ext * lotl_pkg::AllowHighSlope);
    end else begin
      limit = lotl_pkg::AllowMidBase - (bright_ext * lotl_pkg::AllowMidSlope);
    end
  end

  assign has_limit = brightness_i > lotl_pkg::BrightMid;

  // A command longer than its limit is refused unless it is forced.
  assign check_o.refuse = !force_req_i && has_limit &&
      (on_time_ms_i > lotl_pkg::OnTimeWidth'(limit));
  assign check_o.in_range = brightness_i <= lotl_pkg::BrightFull;

endmodule

FILE: hw/rtl/led_on_time_limiter.sv
// ----------------------------------------------------------------------------
// LED on-time limiter
// Guards an LED drive: applies brightness commands within an on-time limit,
// and counts millisecond ticks down to switch the LED off.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the result channel does not stall;
// an accepted transaction passes through the input register and then the result
// register with the state, which form a two-stage pipeline.
// Reset: asynchronous, active low; clears the pipeline, switches the LED off,
// cancels the countdown and loads the full scale with 499.
// ----------------------------------------------------------------------------
module led_on_time_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lotl_pkg::LevelWidth-1:0]  cfg_pwm_full_scale_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [lotl_pkg::BrightWidth-1:0] brightness_i,
  input  logic [lotl_pkg::OnTimeWidth-1:0] on_time_ms_i,
  input  logic                             force_req_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lotl_pkg::LevelWidth-1:0]  pwm_level_o,
  output logic [lotl_pkg::StatusWidth-1:0] status_o,
  output logic                             timer_running_o
);

  localparam int unsigned LW = lotl_pkg::LevelWidth;
  localparam int unsigned TW = lotl_pkg::TimeWidth;
  localparam int unsigned PW = lotl_pkg::ProdWidth;
  localparam int unsigned RW = lotl_pkg::RecipWidth;

  // Configuration register.
  logic [LW-1:0] full_scale_q;

  // Input stage.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_cmd_q;
  logic [PW-1:0]    s1_prod_q;
  lotl_pkg::check_t s1_check_q;
  logic [TW-1:0]    s1_on_time_q;
  logic             s1_on_nz_q;

  // Block state, which also drives the result fields.
  logic [LW-1:0] pwm_q, pwm_d;
  logic [TW-1:0] remain_q, remain_d;
  logic          armed_q, armed_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  lotl_pkg::status_e out_status_q, out_status_d;

  logic             accept;
  logic             res_free;
  logic             s1_adv;
  logic [PW-1:0]    prod_in;
  lotl_pkg::check_t check;
  logic [TW-1:0]    on_time_sat;
  logic [RW-1:0]    recip_prod;
  logic [LW-1:0]    scaled;
  logic [LW+2:0]    seven;
  logic [LW-1:0]    level;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= lotl_pkg::FullScaleReset;
    end else if (cfg_valid_i) begin
      full_scale_q <= cfg_pwm_full_scale_i;
    end
  end

  // Pipeline handshake: the result register frees up as its transaction leaves.
  assign res_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && res_free;
  assign in_ready_o = !s1_valid_q || res_free;
  assign accept     = in_valid_i && in_ready_o;

  // On-time check of the incoming command.
  lotl_limit u_limit (
    .brightness_i (brightness_i),
    .on_time_ms_i (on_time_ms_i),
    .force_req_i  (force_req_i),
    .check_o      (check)
  );

  // Brightness times full scale, registered before the divide by 100.
  assign prod_in = PW'(brightness_i) * PW'(full_scale_q);

  // Countdown value, saturated when the counter is narrower than the field.
  if (TW >= lotl_pkg::OnTimeWidth) begin : g_no_sat
    assign on_time_sat = TW'(on_time_ms_i);
  end else begin : g_sat
    assign on_time_sat = (|on_time_ms_i[lotl_pkg::OnTimeWidth-1:TW]) ? '1 :
                         on_time_ms_i[TW-1:0];
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= cmd_i;
      s1_prod_q    <= prod_in;
      s1_check_q   <= check;
      s1_on_time_q <= on_time_sat;
      s1_on_nz_q   <= |on_time_ms_i;
    end
  end

  // Level: floor(product / 100) by reciprocal, then scaled by 7/8.
  assign recip_prod = RW'(s1_prod_q) * RW'(lotl_pkg::RecipMul);
  assign scaled     = recip_prod[lotl_pkg::RecipShift +: LW];
  assign seven      = {scaled, 3'b000} - (LW + 3)'(scaled);
  assign level      = seven[LW+2:3];

  // State update and result status for the transaction leaving the input stage.
  always_comb begin
    pwm_d        = pwm_q;
    remain_d     = remain_q;
    armed_d      = armed_q;
    out_status_d = out_status_q;
    if (s1_adv) begin
      if (s1_cmd_q == lotl_pkg::CmdBright) begin
        armed_d = 1'b0;
        if (s1_check_q.refuse) begin
          out_status_d = lotl_pkg::StRefused;
        end else begin
          if (s1_check_q.in_range) begin
            pwm_d        = level;
            out_status_d = lotl_pkg::StApplied;
          end else begin
            out_status_d = lotl_pkg::StRange;
          end
          if (s1_on_nz_q) begin
            remain_d = s1_on_time_q;
            armed_d  = 1'b1;
          end
        end
      end else begin
        out_status_d = lotl_pkg::StIdle;
        if (armed_q) begin
          if (remain_q <= TW'(1)) begin
            remain_d     = '0;
            armed_d      = 1'b0;
            pwm_d        = '0;
            out_status_d = lotl_pkg::StExpired;
          end else begin
            remain_d = remain_q - TW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q        <= '0;
      remain_q     <= '0;
      armed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= lotl_pkg::StIdle;
    end else begin
      pwm_q        <= pwm_d;
      remain_q     <= remain_d;
      armed_q      <= armed_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
    end
  end

  // Result fields come straight from the state and the status register.
  assign out_valid_o     = out_valid_q;
  assign pwm_level_o     = pwm_q;
  assign status_o        = out_status_q;
  assign timer_running_o = armed_q;

endmodule

FILE: hw/rtl/lotl_checker.sv
// ----------------------------------------------------------------------------
// LED on-time limiter checker
// Port-level assertions on the limiter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lotl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [lotl_pkg::LevelWidth-1:0]  pwm_level_o,
  input logic [lotl_pkg::StatusWidth-1:0] status_o,
  input logic                             timer_running_o
);

  // Transactions accepted whose results have not been taken yet.
  logic [1:0] pending_q, pending_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A result is never shown without an accepted transaction behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 2'd0))
    else $error("result valid with no accepted transaction pending");

  // The pipeline holds at most two transactions; a full pipeline takes a new
  // one only while its oldest result leaves.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pending_q == 2'd2) && !out_ready_i) |-> !in_ready_o)
    else $error("input ready while two transactions are stuck in flight");

  // An expired countdown switches the LED off and ends the timer.
  a_expired_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lotl_pkg::StExpired)) |->
      ((pwm_level_o == '0) && !timer_running_o))
    else $error("expired result with LED on or timer running");

  // A refused command leaves no countdown pending.
  a_refused_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lotl_pkg::StRefused)) |-> !timer_running_o)
    else $error("refused command left a countdown running");

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pwm_level_o) && $stable(status_o) &&
       $stable(timer_running_o)))
    else $error("stalled result changed");

endmodule

bind led_on_time_limiter lotl_checker u_lotl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .pwm_level_o     (pwm_level_o),
  .status_o        (status_o),
  .timer_running_o (timer_running_o)
);

FILE: test/tb_led_on_time_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED on-time limiter testbench
// Drives brightness commands and millisecond ticks with random gaps on both
// channels and checks each result against an in-bench model of the drive.
// The full scale is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_led_on_time_limiter;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseItems    = 230;
  localparam int unsigned DrainCycles   = 8;

  // One input transaction.
  typedef struct packed {
    logic                             cmd;
    logic [lotl_pkg::BrightWidth-1:0] brightness;
    logic [lotl_pkg::OnTimeWidth-1:0] on_time_ms;
    logic                             force_req;
  } led_item_t;

  // One expected result transaction.
  typedef struct packed {
    logic [lotl_pkg::LevelWidth-1:0] pwm_level;
    lotl_pkg::status_e               status;
    logic                            timer_running;
  } drive_result_t;

  // Model of the LED drive and queue of results still to arrive.
  class led_drive_scoreboard;
    logic [lotl_pkg::LevelWidth-1:0] full_scale = lotl_pkg::FullScaleReset;
    logic [lotl_pkg::LevelWidth-1:0] level      = '0;
    logic [lotl_pkg::TimeWidth-1:0]  remaining  = '0;
    logic                            armed      = 1'b0;
    drive_result_t                   expected_drive_q[$];
    int unsigned                     mismatches = 0;

    function void set_full_scale(logic [lotl_pkg::LevelWidth-1:0] value);
      full_scale = value;
    endfunction

    function int unsigned pending();
      return expected_drive_q.size();
    endfunction

    // Longest on-time allowed for a brightness; zero means no limit.
    function int unsigned allowed_on_time(logic [lotl_pkg::BrightWidth-1:0] b);
      if (b >= 100) return 500;
      if (b > 50) return 1500 - 10 * int'(b);
      if (b > 30) return 148500 - 2950 * int'(b);
      return 0;
    endfunction

    function logic [lotl_pkg::LevelWidth-1:0] scaled_level(
        logic [lotl_pkg::BrightWidth-1:0] b);
      int unsigned scaled;
      scaled = (int'(b) * int'(full_scale)) / 100;
      return lotl_pkg::LevelWidth'((scaled * 7) / 8);
    endfunction

    // Advances the drive state by one accepted transaction.
    function void note_command(led_item_t it);
      drive_result_t res;
      int unsigned   lim;
      if (it.cmd == lotl_pkg::CmdBright) begin
        lim   = allowed_on_time(it.brightness);
        armed = 1'b0;
        if (!it.force_req && lim != 0 && it.on_time_ms > lim) begin
          res.status = lotl_pkg::StRefused;
        end else begin
          if (it.brightness <= 100) begin
            level      = scaled_level(it.brightness);
            res.status = lotl_pkg::StApplied;
          end else begin
            res.status = lotl_pkg::StRange;
          end
          if (it.on_time_ms != 0) begin
            remaining = lotl_pkg::TimeWidth'(it.on_time_ms);
            armed     = 1'b1;
          end
        end
      end else begin
        res.status = lotl_pkg::StIdle;
        if (armed) begin
          if (remaining <= 1) begin
            remaining  = '0;
            armed      = 1'b0;
            level      = '0;
            res.status = lotl_pkg::StExpired;
          end else begin
            remaining = remaining - 1'b1;
          end
        end
      end
      res.pwm_level     = level;
      res.timer_running = armed;
      expected_drive_q  = {expected_drive_q, res};
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(logic [lotl_pkg::LevelWidth-1:0] pwm,
                      logic [lotl_pkg::StatusWidth-1:0] st, logic running);
      drive_result_t exp_res;
      if (expected_drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pwm=%0d status=%0d", pwm, st));
        return;
      end
      exp_res = expected_drive_q.pop_front();
      if (pwm !== exp_res.pwm_level)
        report_mismatch($sformatf("pwm_level %0d, expected %0d", pwm, exp_res.pwm_level));
      if (st !== exp_res.status)
        report_mismatch($sformatf("status %0d, expected %s", st, exp_res.status.name()));
      if (running !== exp_res.timer_running)
        report_mismatch($sformatf("timer_running %0b, expected %0b", running,
                                  exp_res.timer_running));
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [lotl_pkg::LevelWidth-1:0]  cfg_pwm_full_scale_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             cmd_i;
  logic [lotl_pkg::BrightWidth-1:0] brightness_i;
  logic [lotl_pkg::OnTimeWidth-1:0] on_time_ms_i;
  logic                             force_req_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [lotl_pkg::LevelWidth-1:0]  pwm_level_o;
  logic [lotl_pkg::StatusWidth-1:0] status_o;
  logic                             timer_running_o;

  led_drive_scoreboard sb;
  bit                  send_steady;
  bit                  recv_steady;
  int unsigned         stall_cycles;

  led_on_time_limiter i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pwm_full_scale_i (cfg_pwm_full_scale_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .cmd_i                (cmd_i),
    .brightness_i         (brightness_i),
    .on_time_ms_i         (on_time_ms_i),
    .force_req_i          (force_req_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .pwm_level_o          (pwm_level_o),
    .status_o             (status_o),
    .timer_running_o      (timer_running_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #(ClkHalf);
    clk_i = 1'b0;
    #(ClkHalf);
  end

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic led_item_t bright_item(int unsigned b, int unsigned t, bit f);
    led_item_t it;
    it.cmd        = lotl_pkg::CmdBright;
    it.brightness = lotl_pkg::BrightWidth'(b);
    it.on_time_ms = lotl_pkg::OnTimeWidth'(t);
    it.force_req  = f;
    return it;
  endfunction

  function automatic led_item_t tick_item();
    led_item_t it;
    it.cmd        = lotl_pkg::CmdTick;
    it.brightness = lotl_pkg::BrightWidth'($urandom);
    it.on_time_ms = lotl_pkg::OnTimeWidth'($urandom);
    it.force_req  = 1'($urandom);
    return it;
  endfunction

  // Mostly ticks; commands favor region edges and short on-times so that
  // countdowns run out often.
  function automatic led_item_t make_random_item();
    led_item_t   it;
    int unsigned lim;
    it = tick_item();
    if ($urandom_range(0, 9) < 4) begin
      it.cmd = lotl_pkg::CmdBright;
      case ($urandom_range(0, 5))
        0:       it.brightness = lotl_pkg::BrightWidth'($urandom_range(0, 30));
        1:       it.brightness = lotl_pkg::BrightWidth'($urandom_range(31, 50));
        2:       it.brightness = lotl_pkg::BrightWidth'($urandom_range(51, 99));
        3:       it.brightness = lotl_pkg::BrightWidth'(100);
        4:       it.brightness = lotl_pkg::BrightWidth'($urandom_range(101, 255));
        default: it.brightness = lotl_pkg::BrightWidth'($urandom);
      endcase
      it.force_req = ($urandom_range(0, 3) == 0);
      lim = sb.allowed_on_time(it.brightness);
      case ($urandom_range(0, 4))
        0: it.on_time_ms = '0;
        1: it.on_time_ms = lotl_pkg::OnTimeWidth'($urandom_range(1, 40));
        2: it.on_time_ms = (lim != 0) ?
                           lotl_pkg::OnTimeWidth'(lim - 2 + $urandom_range(0, 4)) :
                           lotl_pkg::OnTimeWidth'($urandom_range(1, 200));
        3: it.on_time_ms = lotl_pkg::OnTimeWidth'($urandom_range(1, 300));
        default: it.on_time_ms = lotl_pkg::OnTimeWidth'($urandom);
      endcase
    end
    return it;
  endfunction

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic send_item(led_item_t it);
    int unsigned gap;
    gap = draw_gap(send_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= it.cmd;
    brightness_i <= it.brightness;
    on_time_ms_i <= it.on_time_ms;
    force_req_i  <= it.force_req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(it);
  endtask

  // Stops offering input and waits for every outstanding result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_full_scale(logic [lotl_pkg::LevelWidth-1:0] value);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_pwm_full_scale_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_full_scale(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stall before each result transaction.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = draw_gap(recv_steady);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Result checking.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(pwm_level_o, status_o, timer_running_o);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [lotl_pkg::LevelWidth-1:0] scale;
    sb                   = new();
    stall_cycles         = 0;
    send_steady          = 1'b0;
    recv_steady          = 1'b0;
    rst_ni               = 1'b0;
    cfg_valid_i          = 1'b0;
    cfg_pwm_full_scale_i = '0;
    in_valid_i           = 1'b0;
    cmd_i                = lotl_pkg::CmdTick;
    brightness_i         = '0;
    on_time_ms_i         = '0;
    force_req_i          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the full scale left at its reset value.
    send_item(tick_item());                // tick with no countdown
    send_item(bright_item(100, 0, 0));     // full brightness, stay on
    send_item(bright_item(100, 500, 0));   // exactly at the limit
    send_item(bright_item(100, 501, 0));   // one over: refused, level kept
    send_item(bright_item(100, 501, 1));   // forced past the limit
    send_item(bright_item(255, 3, 0));     // out of range still arms the timer
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());                // countdown runs out
    send_item(bright_item(51, 990, 0));    // top of the upper slope
    send_item(bright_item(51, 991, 0));
    send_item(bright_item(50, 1000, 0));   // lower slope boundary
    send_item(bright_item(31, 57051, 0));
    send_item(bright_item(30, (1 << lotl_pkg::OnTimeWidth) - 1, 0));  // no limit
    send_item(bright_item(0, 1, 0));
    send_item(tick_item());
    send_item(bright_item(101, 0, 0));
    send_item(tick_item());
    send_item(bright_item(255, (1 << lotl_pkg::OnTimeWidth) - 1, 1));
    send_item(bright_item(75, 2, 0));
    send_item(tick_item());
    send_item(tick_item());
    settle();

    // Random phases, each with its own full scale and idling pattern.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       scale = '1;
        1:       scale = lotl_pkg::LevelWidth'(1);
        2:       scale = '0;
        3:       scale = lotl_pkg::FullScaleReset;
        default: scale = lotl_pkg::LevelWidth'(
                           $urandom_range(1, (1 << lotl_pkg::LevelWidth) - 1));
      endcase
      write_full_scale(scale);
      send_steady = (p % 4 == 1);
      recv_steady = (p % 4 == 2);
      repeat (PhaseItems) send_item(make_random_item());
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
